[hw/rtl/sltab_pkg.sv]
// ----------------------------------------------------------------------------
// sltab_pkg: shared types for the sorted list table
// Command and status codes, controller states and the command bundle that
// the controller drives into the datapath.
// ----------------------------------------------------------------------------
package sltab_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2
    } t_command;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_ABSENT = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_EXEC   = 2'd1,
        S_REPORT = 2'd2
    } t_state;

    typedef struct packed {
        logic load;     // capture the incoming transaction
        logic exec;     // apply the command to the table
        logic publish;  // move the result into the output register
    } t_ctl_cmd;

endpackage

[hw/rtl/sltab_ctrl.sv]
// ----------------------------------------------------------------------------
// sltab_ctrl: sequencing controller
// Walks each command through load, execute and report, and owns the
// output valid flag of the result register.
// ----------------------------------------------------------------------------
module sltab_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sltab_pkg::t_ctl_cmd o_cmd
);

    sltab_pkg::t_state r_state;
    sltab_pkg::t_state n_state;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sltab_pkg::S_IDLE: begin
                if (i_in_valid) n_state = sltab_pkg::S_EXEC;
            end
            sltab_pkg::S_EXEC: begin
                n_state = sltab_pkg::S_REPORT;
            end
            sltab_pkg::S_REPORT: begin
                // hold until the output register can take the result
                if (w_slot_free) n_state = sltab_pkg::S_IDLE;
            end
            default: begin
                n_state = sltab_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = (r_state == sltab_pkg::S_IDLE);
        o_cmd.load    = (r_state == sltab_pkg::S_IDLE) && i_in_valid;
        o_cmd.exec    = (r_state == sltab_pkg::S_EXEC);
        o_cmd.publish = (r_state == sltab_pkg::S_REPORT) && w_slot_free;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        priority if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sltab_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[hw/rtl/sltab_datapath.sv]
// ----------------------------------------------------------------------------
// sltab_datapath: sorted cell row and result register
// Every cell compares its entry with the operand in parallel; insert shifts
// the upper cells up by one, delete shifts them down over the first match.
// ----------------------------------------------------------------------------
module sltab_datapath #(
    parameter int TABLE_DEPTH = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sltab_pkg::t_ctl_cmd                  i_cmd,
    input  logic [1:0]                           i_command,
    input  logic signed [VALUE_BITS-1:0]         i_value,
    output logic [1:0]                           o_status,
    output logic                                 o_found,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]     o_entry_total,
    output logic signed [VALUE_BITS-1:0]         o_smallest,
    output logic signed [VALUE_BITS-1:0]         o_largest
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = $clog2(TABLE_DEPTH);

    logic signed [VALUE_BITS-1:0] r_entries [TABLE_DEPTH];
    logic signed [VALUE_BITS-1:0] n_entries [TABLE_DEPTH];
    logic signed [VALUE_BITS-1:0] w_lower   [TABLE_DEPTH];
    logic signed [VALUE_BITS-1:0] w_upper   [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]       w_used;
    logic [TABLE_DEPTH-1:0]       w_less;   // operand below entry
    logic [TABLE_DEPTH-1:0]       w_match;
    logic [TABLE_DEPTH-1:0]       w_at_or_above;
    logic [TABLE_DEPTH-1:0]       w_prev_less;
    logic [TABLE_DEPTH-1:0]       w_next_used;
    logic [TABLE_DEPTH-1:0]       w_at_end;

    logic [CW-1:0]                r_count;
    logic [CW-1:0]                n_count;
    logic signed [VALUE_BITS-1:0] r_value;
    sltab_pkg::t_command          r_command;
    sltab_pkg::t_status           r_status;
    sltab_pkg::t_status           n_status;
    logic                         r_found;
    logic                         w_had;
    logic                         w_full;
    logic                         w_empty;
    logic                         w_do_insert;
    logic                         w_do_delete;
    logic [IW-1:0]                w_last_idx;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            assign w_used[g]        = CW'(g) < r_count;
            assign w_less[g]        = w_used[g] && (r_value < r_entries[g]);
            assign w_match[g]       = w_used[g] && (r_entries[g] == r_value);
            assign w_at_or_above[g] = !(r_entries[g] < r_value);
            assign w_at_end[g]      = CW'(g) == r_count;

            if (g == 0) begin : g_first
                assign w_lower[g]     = r_entries[g];
                assign w_prev_less[g] = 1'b0;
            end else begin : g_inner_lo
                assign w_lower[g]     = r_entries[g-1];
                assign w_prev_less[g] = w_less[g-1];
            end

            if (g == TABLE_DEPTH - 1) begin : g_last
                assign w_upper[g]     = r_entries[g];
                assign w_next_used[g] = 1'b0;
            end else begin : g_inner_hi
                assign w_upper[g]     = r_entries[g+1];
                assign w_next_used[g] = w_used[g+1];
            end

            always_comb begin
                n_entries[g] = r_entries[g];
                priority if (w_do_insert) begin
                    // entries above the slot move up; the slot takes the operand
                    if (w_prev_less[g]) begin
                        n_entries[g] = w_lower[g];
                    end else if (w_less[g] || w_at_end[g]) begin
                        n_entries[g] = r_value;
                    end
                end else if (w_do_delete) begin
                    if (w_next_used[g] && w_at_or_above[g]) begin
                        n_entries[g] = w_upper[g];
                    end
                end else begin
                    n_entries[g] = r_entries[g];
                end
            end

            always_ff @(posedge i_clk) begin
                r_entries[g] <= n_entries[g];
            end
        end
    endgenerate

    assign w_had   = |w_match;
    assign w_full  = r_count == CW'(TABLE_DEPTH);
    assign w_empty = r_count == '0;

    always_comb begin
        w_do_insert = 1'b0;
        w_do_delete = 1'b0;
        n_status    = sltab_pkg::STAT_OK;
        n_count     = r_count;
        if (i_cmd.exec) begin
            unique case (r_command)
                sltab_pkg::CMD_INSERT: begin
                    if (w_full) begin
                        n_status = sltab_pkg::STAT_FULL;
                    end else begin
                        w_do_insert = 1'b1;
                        n_count     = r_count + CW'(1);
                    end
                end
                sltab_pkg::CMD_DELETE: begin
                    priority if (w_empty) begin
                        n_status = sltab_pkg::STAT_EMPTY;
                    end else if (!w_had) begin
                        n_status = sltab_pkg::STAT_ABSENT;
                    end else begin
                        w_do_delete = 1'b1;
                        n_count     = r_count - CW'(1);
                    end
                end
                default: begin
                    // search, and the unused code, leave the table alone
                    n_status = sltab_pkg::STAT_OK;
                end
            endcase
        end
    end

    assign w_last_idx = IW'(r_count - CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command <= sltab_pkg::t_command'(i_command);
            r_value   <= i_value;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_found  <= w_had;
        end
        if (i_cmd.publish) begin
            o_status      <= r_status;
            o_found       <= r_found;
            o_entry_total <= r_count;
            o_smallest    <= w_empty ? '0 : r_entries[0];
            o_largest     <= w_empty ? '0 : r_entries[w_last_idx];
        end
    end

endmodule

[hw/rtl/sorted_list_table.sv]
// ----------------------------------------------------------------------------
// sorted_list_table: bounded ascending multiset of signed values
// Top level: controller plus sorted cell datapath.
// ----------------------------------------------------------------------------
// Each transaction carries a command (insert, delete one occurrence, search)
// and a value; each returns one result with status, found flag, count, and
// the smallest and largest stored values (zero when empty). A command is
// captured when accepted, then all cells compare and shift in parallel, and
// then the result is loaded into the output register, waiting while that
// register still holds an unaccepted result. The output register is separate
// from the input side, so the next command is accepted while an earlier result
// still waits; a new command is accepted only once the last one is published.
module sorted_list_table #(
    parameter int TABLE_DEPTH = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_command,
    input  logic signed [VALUE_BITS-1:0]         i_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [1:0]                           o_status,
    output logic                                 o_found,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]     o_entry_total,
    output logic signed [VALUE_BITS-1:0]         o_smallest,
    output logic signed [VALUE_BITS-1:0]         o_largest
);

    sltab_pkg::t_ctl_cmd w_cmd;

    sltab_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    sltab_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_command     (i_command),
        .i_value       (i_value),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_entry_total (o_entry_total),
        .o_smallest    (o_smallest),
        .o_largest     (o_largest)
    );

endmodule

[verif/tb_sorted_list_table.sv]
// ----------------------------------------------------------------------------
// tb_sorted_list_table: self-checking bench for the sorted list table
// Drives insert, delete and search transactions through the input channel.
// An in-bench table model predicts each result, and the result stream is
// compared field by field in order. Both channels idle at random, and a
// long output stall forces the block to back up its input.
// ----------------------------------------------------------------------------
module tb_sorted_list_table;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 16;
    localparam int VBITS       = 32;
    localparam int TBITS       = $clog2(DEPTH + 1);
    localparam int RANDOM_OPS  = 1325;
    localparam int HOLD_CYCLES = 160;
    localparam int SETTLE      = 20;
    localparam int REPORT_MAX  = 10;
    // encoding left over by the package; the block treats it as a search
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam logic signed [VBITS-1:0] VAL_MIN = {1'b1, {(VBITS-1){1'b0}}};
    localparam logic signed [VBITS-1:0] VAL_MAX = {1'b0, {(VBITS-1){1'b1}}};

    typedef struct {
        logic [1:0]              command;
        logic signed [VBITS-1:0] value;
        bit                      wait_drain;
    } t_table_op;

    typedef struct {
        logic [1:0]              command;
        sltab_pkg::t_status      status;
        logic                    found;
        logic [TBITS-1:0]        total;
        logic signed [VBITS-1:0] smallest;
        logic signed [VBITS-1:0] largest;
    } t_table_result;

    logic                    i_clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic [1:0]              command = sltab_pkg::CMD_INSERT;
    logic signed [VBITS-1:0] value = '0;
    logic                    out_ready = 1'b0;
    logic                    hold_off = 1'b0;
    logic [1:0]              phase = 2'd0;

    logic                    o_in_ready;
    logic                    o_out_valid;
    logic [1:0]              o_status;
    logic                    o_found;
    logic [TBITS-1:0]        o_entry_total;
    logic signed [VBITS-1:0] o_smallest;
    logic signed [VBITS-1:0] o_largest;

    t_table_op     pending_ops[$];
    t_table_result expected_results[$];

    // shadow of the table contents
    logic signed [VBITS-1:0] stored_vals [DEPTH];
    int                      stored_count = 0;

    int ops_sent       = 0;
    int results_seen   = 0;
    int result_errors  = 0;
    int full_refusals  = 0;
    int empty_deletes  = 0;
    int absent_deletes = 0;
    int search_hits    = 0;
    int total_ops;

    sorted_list_table #(
        .TABLE_DEPTH (DEPTH),
        .VALUE_BITS  (VBITS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (command),
        .i_value       (value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_entry_total (o_entry_total),
        .o_smallest    (o_smallest),
        .o_largest     (o_largest)
    );

    always #5 i_clk = ~i_clk;

    // Apply one command to the shadow table and return the result it causes.
    function automatic t_table_result apply_table_command(input logic [1:0] cmd,
                                                          input logic signed [VBITS-1:0] val);
        t_table_result res;
        int            pos;
        int            idx;
        logic          had;
        had = 1'b0;
        for (idx = 0; idx < stored_count; idx++) begin
            if (stored_vals[idx] == val) had = 1'b1;
        end
        res.command = cmd;
        res.status  = sltab_pkg::STAT_OK;
        res.found   = had;
        case (cmd)
            sltab_pkg::CMD_INSERT: begin
                if (stored_count >= DEPTH) begin
                    res.status = sltab_pkg::STAT_FULL;
                end else begin
                    // place after any equal values
                    pos = 0;
                    while (pos < stored_count && !(val < stored_vals[pos])) pos++;
                    for (idx = stored_count; idx > pos; idx--)
                        stored_vals[idx] = stored_vals[idx-1];
                    stored_vals[pos] = val;
                    stored_count++;
                end
            end
            sltab_pkg::CMD_DELETE: begin
                if (stored_count == 0) begin
                    res.status = sltab_pkg::STAT_EMPTY;
                end else if (!had) begin
                    res.status = sltab_pkg::STAT_ABSENT;
                end else begin
                    pos = 0;
                    while (stored_vals[pos] != val) pos++;
                    for (idx = pos; idx + 1 < stored_count; idx++)
                        stored_vals[idx] = stored_vals[idx+1];
                    stored_count--;
                end
            end
            default: ;
        endcase
        res.total = TBITS'(stored_count);
        if (stored_count == 0) begin
            res.smallest = '0;
            res.largest  = '0;
        end else begin
            res.smallest = stored_vals[0];
            res.largest  = stored_vals[stored_count-1];
        end
        return res;
    endfunction

    // Driver: predict on each accepted transaction, then offer the next one.
    always @(posedge i_clk) begin : driver
        t_table_op op;
        bit        slot_free;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            slot_free = !in_valid;
            if (in_valid && o_in_ready) begin
                expected_results.push_back(apply_table_command(command, value));
                ops_sent++;
                slot_free = 1'b1;
            end
            phase <= (ops_sent < total_ops / 3) ? 2'd0 :
                     (ops_sent < 2 * total_ops / 3) ? 2'd1 : 2'd2;
            if (slot_free) begin
                if (pending_ops.size() != 0 &&
                    !(pending_ops[0].wait_drain && expected_results.size() != 0) &&
                    $urandom_range(99) >= ((phase == 2'd0) ? 16 : (phase == 2'd1) ? 53 : 0))
                begin
                    op = pending_ops.pop_front();
                    in_valid <= 1'b1;
                    command  <= op.command;
                    value    <= op.value;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= !hold_off &&
                         $urandom_range(99) >= ((phase == 2'd0) ? 53 : (phase == 2'd1) ? 16 : 0);
        end
    end

    // Monitor: compare every accepted result with the oldest prediction.
    always @(posedge i_clk) begin : monitor
        t_table_result exp_res;
        if (rst_n && o_out_valid && out_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                result_errors++;
                if (result_errors <= REPORT_MAX)
                    $display("ERROR: unexpected result status=%0d found=%0b total=%0d",
                             o_status, o_found, o_entry_total);
            end else begin
                exp_res = expected_results.pop_front();
                if (exp_res.status == sltab_pkg::STAT_FULL) full_refusals++;
                if (exp_res.status == sltab_pkg::STAT_EMPTY) empty_deletes++;
                if (exp_res.status == sltab_pkg::STAT_ABSENT) absent_deletes++;
                if (exp_res.command != sltab_pkg::CMD_INSERT &&
                    exp_res.command != sltab_pkg::CMD_DELETE && exp_res.found)
                    search_hits++;
                if (o_status !== exp_res.status || o_found !== exp_res.found ||
                    o_entry_total !== exp_res.total || o_smallest !== exp_res.smallest ||
                    o_largest !== exp_res.largest) begin
                    result_errors++;
                    if (result_errors <= REPORT_MAX) begin
                        $display("ERROR: result %0d (command %0d) mismatch", results_seen,
                                 exp_res.command);
                        $display("  expected status=%0d found=%0b total=%0d min=%0d max=%0d",
                                 exp_res.status, exp_res.found, exp_res.total,
                                 exp_res.smallest, exp_res.largest);
                        $display("  actual   status=%0d found=%0b total=%0d min=%0d max=%0d",
                                 o_status, o_found, o_entry_total, o_smallest, o_largest);
                    end
                end
            end
        end
    end

    // Stall the output for a long stretch so the table backs up its input.
    initial begin
        while (ops_sent < 1000) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("ERROR: timeout with %0d results outstanding", expected_results.size());
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        t_table_op               op;
        logic signed [VBITS-1:0] pool [6];
        int                      burst_left;
        int                      insert_pct;
        int                      roll;
        int                      n;

        for (n = 0; n < DEPTH; n++) stored_vals[n] = '0;

        // empty table cases
        pending_ops.push_back('{sltab_pkg::CMD_DELETE, '0, 1'b0});
        pending_ops.push_back('{sltab_pkg::CMD_SEARCH, 32'sd5, 1'b0});
        pending_ops.push_back('{CMD_SPARE, '0, 1'b0});
        // value extremes, a duplicate, hits and misses
        pending_ops.push_back('{sltab_pkg::CMD_INSERT, VAL_MAX, 1'b0});
        pending_ops.push_back('{sltab_pkg::CMD_INSERT, VAL_MIN, 1'b0});
        pending_ops.push_back('{sltab_pkg::CMD_INSERT, '0, 1'b0});
        pending_ops.push_back('{sltab_pkg::CMD_INSERT, -32'sd1, 1'b0});
        pending_ops.push_back('{sltab_pkg::CMD_INSERT, 32'sd1, 1'b0});
        pending_ops.push_back('{sltab_pkg::CMD_INSERT, '0, 1'b0});
        pending_ops.push_back('{sltab_pkg::CMD_SEARCH, '0, 1'b0});
        pending_ops.push_back('{sltab_pkg::CMD_SEARCH, 32'sd7, 1'b0});
        pending_ops.push_back('{CMD_SPARE, -32'sd1, 1'b0});
        pending_ops.push_back('{sltab_pkg::CMD_DELETE, 32'sd7, 1'b0});
        pending_ops.push_back('{sltab_pkg::CMD_DELETE, '0, 1'b0});
        // fill up, then one refused insert
        for (n = 0; n < 12; n++)
            pending_ops.push_back('{sltab_pkg::CMD_INSERT, $signed($urandom), 1'b0});

        // random bursts that lean toward filling or draining the table
        burst_left = 0;
        insert_pct = 50;
        for (n = 0; n < RANDOM_OPS; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(20, 60);
                insert_pct = ($urandom_range(1) != 0) ? 70 : 25;
                foreach (pool[k])
                    pool[k] = ($urandom_range(1) != 0) ?
                              $signed($urandom_range(40)) - 32'sd20 : $signed($urandom);
            end
            burst_left--;
            roll = $urandom_range(99);
            op.command = (roll < insert_pct) ? sltab_pkg::CMD_INSERT :
                         (roll < 87) ? sltab_pkg::CMD_DELETE :
                         (roll < 97) ? sltab_pkg::CMD_SEARCH : CMD_SPARE;
            roll = $urandom_range(99);
            if (roll < 60)
                op.value = pool[$urandom_range(5)];
            else if (roll < 85)
                op.value = $signed($urandom);
            else
                case ($urandom_range(3))
                    0:       op.value = VAL_MIN;
                    1:       op.value = VAL_MAX;
                    2:       op.value = '0;
                    default: op.value = -32'sd1;
                endcase
            // hold the sender until every result is back
            op.wait_drain = (n == 0 || n == 600);
            pending_ops.push_back(op);
        end
        total_ops = pending_ops.size();

        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || in_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (expected_results.size() != 0) result_errors++;

        $display("Ran %0d commands, checked %0d results; %0d errors.", ops_sent,
                 results_seen, result_errors);
        $display("Saw %0d full refusals, %0d empty deletes, %0d absent deletes, %0d search hits.",
                 full_refusals, empty_deletes, absent_deletes, search_hits);
        if (result_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/sltab_pkg.sv
hw/rtl/sltab_ctrl.sv
hw/rtl/sltab_datapath.sv
hw/rtl/sorted_list_table.sv
verif/tb_sorted_list_table.sv
